// ===== design/cpualu_pkg.sv =====
// shared types and operation codes for the 8-bit cpu alu
`timescale 1ns / 1ps

package cpualu_pkg;

	// operation codes carried in the op field of an input item
	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_ADC   = 4'd1,
		OP_SUB   = 4'd2,
		OP_CP    = 4'd3,
		OP_AND   = 4'd4,
		OP_OR    = 4'd5,
		OP_XOR   = 4'd6,
		OP_INC8  = 4'd7,
		OP_DEC8  = 4'd8,
		OP_DAA   = 4'd9,
		OP_ADD16 = 4'd10,
		OP_INC16 = 4'd11
	} alu_op_t;

	// bcd adjust constants
	localparam logic [7:0] DAA_LO_FIX  = 8'h06;
	localparam logic [7:0] DAA_HI_FIX  = 8'h60;
	localparam logic [3:0] BCD_MAX_LO  = 4'h9;
	localparam logic [7:0] BCD_MAX     = 8'h99;

	// input item: operation, operands and incoming flags
	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] first_operand;
		logic [15:0] second_operand;
		logic        zero_in;
		logic        subtract_in;
		logic        half_in;
		logic        carry_in;
	} req_t;

	// result item: value, destination write enable and outgoing flags
	typedef struct packed {
		logic [15:0] result_value;
		logic        write_dest;
		logic        zero_out;
		logic        subtract_out;
		logic        half_out;
		logic        carry_out;
	} rsp_t;

endpackage

// ===== design/cpualu_stream_if.sv =====
// valid/ready channel carrying one item per handshake
`timescale 1ns / 1ps

interface cpualu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/cpu_alu_8bit_with_flags_core.sv =====
// top level: input register, alu datapath and result register
// an accepted input item passes through the input register and then the result register
// throughput: one item per cycle while the result side does not stall, through the two-stage register pipeline
// a waiting result holds in the result register while the next item is taken
// reset clears both stage valid bits; payload registers are not reset
`timescale 1ns / 1ps

module cpu_alu_8bit_with_flags_core (
	input  logic           clk,
	input  logic           arst_n,
	cpualu_stream_if.sink   req,
	cpualu_stream_if.source rsp
);

	logic              valid_s1;
	cpualu_pkg::req_t  item_s1;
	logic              valid_s2;
	cpualu_pkg::rsp_t  res_s2;
	cpualu_pkg::rsp_t  res_next;
	logic              adv_s1;
	logic              adv_s2;

	// stage advance: a stage loads when it is empty or its content moves on
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= req.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid)
			item_s1 <= req.data;
	end

	cpualu_exec u_exec (
		.item (item_s1),
		.res  (res_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1)
			res_s2 <= res_next;
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

endmodule

// ===== design/cpualu_exec.sv =====
// combinational alu datapath: result value and flags for one item
`timescale 1ns / 1ps

module cpualu_exec (
	input  cpualu_pkg::req_t item,
	output cpualu_pkg::rsp_t res
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic [8:0]  sum9;
	logic [4:0]  sum_lo;
	logic [8:0]  diff9;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [7:0]  daa_off;
	logic        daa_carry;
	logic [7:0]  daa_res;
	logic [16:0] sum17;
	logic [12:0] sum12;
	logic [15:0] inc16;

	assign a = item.first_operand[7:0];
	assign b = item.second_operand[7:0];

	// byte add with optional carry in
	assign cin    = (item.op == cpualu_pkg::OP_ADC) ? item.carry_in : 1'b0;
	assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
	assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};

	// byte subtract, top bit is the borrow
	assign diff9 = {1'b0, a} - {1'b0, b};

	assign inc8 = a + 8'd1;
	assign dec8 = a - 8'd1;

	// decimal adjust after add or subtract
	always_comb begin
		daa_off   = 8'd0;
		daa_carry = item.carry_in;
		if (item.subtract_in) begin
			if (item.half_in)
				daa_off = daa_off | cpualu_pkg::DAA_LO_FIX;
			if (item.carry_in)
				daa_off = daa_off | cpualu_pkg::DAA_HI_FIX;
			daa_res = a - daa_off;
		end else begin
			if ((a[3:0] > cpualu_pkg::BCD_MAX_LO) || item.half_in)
				daa_off = daa_off | cpualu_pkg::DAA_LO_FIX;
			if ((a > cpualu_pkg::BCD_MAX) || item.carry_in) begin
				daa_off   = daa_off | cpualu_pkg::DAA_HI_FIX;
				daa_carry = 1'b1;
			end
			daa_res = a + daa_off;
		end
	end

	// sixteen-bit add and increment
	assign sum17 = {1'b0, item.first_operand} + {1'b0, item.second_operand};
	assign sum12 = {1'b0, item.first_operand[11:0]} + {1'b0, item.second_operand[11:0]};
	assign inc16 = item.first_operand + 16'd1;

	// select result and flags, untouched flags pass through
	always_comb begin
		res.result_value = 16'd0;
		res.write_dest   = 1'b1;
		res.zero_out     = item.zero_in;
		res.subtract_out = item.subtract_in;
		res.half_out     = item.half_in;
		res.carry_out    = item.carry_in;
		case (item.op)
			cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
				res.result_value = {8'd0, sum9[7:0]};
				res.zero_out     = (sum9[7:0] == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = sum_lo[4];
				res.carry_out    = sum9[8];
			end
			cpualu_pkg::OP_SUB, cpualu_pkg::OP_CP: begin
				res.result_value = {8'd0, diff9[7:0]};
				res.write_dest   = (item.op == cpualu_pkg::OP_SUB);
				res.zero_out     = (diff9[7:0] == 8'd0);
				res.subtract_out = 1'b1;
				res.half_out     = (a[3:0] < b[3:0]);
				res.carry_out    = diff9[8];
			end
			cpualu_pkg::OP_AND: begin
				res.result_value = {8'd0, a & b};
				res.zero_out     = ((a & b) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b1;
				res.carry_out    = 1'b0;
			end
			cpualu_pkg::OP_OR: begin
				res.result_value = {8'd0, a | b};
				res.zero_out     = ((a | b) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = 1'b0;
			end
			cpualu_pkg::OP_XOR: begin
				res.result_value = {8'd0, a ^ b};
				res.zero_out     = ((a ^ b) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = 1'b0;
			end
			cpualu_pkg::OP_INC8: begin
				res.result_value = {8'd0, inc8};
				res.zero_out     = (inc8 == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = (inc8[3:0] == 4'h0);
			end
			cpualu_pkg::OP_DEC8: begin
				res.result_value = {8'd0, dec8};
				res.zero_out     = (dec8 == 8'd0);
				res.subtract_out = 1'b1;
				res.half_out     = (dec8[3:0] == 4'hF);
			end
			cpualu_pkg::OP_DAA: begin
				res.result_value = {8'd0, daa_res};
				res.zero_out     = (daa_res == 8'd0);
				res.half_out     = 1'b0;
				res.carry_out    = daa_carry;
			end
			cpualu_pkg::OP_ADD16: begin
				res.result_value = sum17[15:0];
				res.subtract_out = 1'b0;
				res.half_out     = sum12[12];
				res.carry_out    = sum17[16];
			end
			cpualu_pkg::OP_INC16: begin
				res.result_value = inc16;
			end
			default: begin
				res.result_value = 16'd0;
				res.write_dest   = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/cpualu_checker.sv =====
// port-level checks for the alu core, bound to the top level
`timescale 1ns / 1ps

module cpualu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input cpualu_pkg::rsp_t rsp_data
);

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result item changed or dropped");

	// a new result item traces back to an accepted input item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result item without matching input item");

	// items that write nothing (compare, unused codes) carry a byte result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.write_dest |-> rsp_data.result_value[15:8] == 8'd0)
		else $error("non-writing item with wide result");

	// a non-zero result that is not written comes from compare, which sets subtract
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.write_dest && rsp_data.result_value != 16'd0
			|-> rsp_data.subtract_out)
		else $error("compare result without subtract flag");

endmodule

bind cpu_alu_8bit_with_flags_core cpualu_checker u_cpualu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
